FILE: rtl/usm_pkg.sv
`default_nettype none
// ============================================================================
// UV sphere mesh unit package
// Shared widths, constants, codes, item types and the rounding helper.
// ============================================================================
package usm_pkg;

    localparam int COORD_W     = 9;
    localparam int RADIUS_W    = 16;
    localparam int POS_W       = 17;
    localparam int NORM_W      = 16;
    localparam int TEX_W       = 17;
    localparam int INDEX_W     = 17;
    localparam int DIVISOR_W   = 10;
    localparam int ANGLE_W     = 32;
    localparam int ANGLE_QW    = 33;
    localparam int TEX_QW      = 17;
    localparam int DIV_STAGES  = 33;
    localparam int SINE_STAGES = 7;
    localparam int CHAIN_LEN   = DIV_STAGES + SINE_STAGES + 4;

    localparam logic [COORD_W-1:0] MIN_WIDTH_SEGMENTS  = 9'd3;
    localparam logic [COORD_W-1:0] MIN_HEIGHT_SEGMENTS = 9'd2;

    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [TEX_W-1:0]   TEX_ONE      = 17'h1_0000;
    localparam logic [30:0]        Q30_ONE      = 31'h4000_0000;
    localparam logic [30:0]        K1           = 31'd1686629713;
    localparam logic [30:0]        K3           = 31'd693598668;
    localparam logic [30:0]        K5           = 31'd85569306;
    localparam logic [30:0]        K7           = 31'd5026995;
    localparam logic [30:0]        K9           = 31'd172272;

    localparam logic [63:0] DIR_LIMIT  = 64'h4000_0000;
    localparam logic [63:0] NORM_LIMIT = 64'd32767;
    localparam logic [63:0] POS_LIMIT  = 64'd65535;

    typedef enum logic {
        OP_VERTEX = 1'b0,
        OP_QUAD   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        CFG_RADIUS          = 2'd0,
        CFG_WIDTH_SEGMENTS  = 2'd1,
        CFG_HEIGHT_SEGMENTS = 2'd2
    } cfg_index_t;

    typedef struct packed {
        op_t              op;
        logic [INDEX_W-1:0] idx_a;
        logic [INDEX_W-1:0] idx_b;
        logic [TEX_W-1:0]   tex_u;
        logic [TEX_W-1:0]   tex_v;
    } side_t;

    typedef struct packed {
        op_t                      op;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic signed [NORM_W-1:0] norm_x;
        logic signed [NORM_W-1:0] norm_y;
        logic signed [NORM_W-1:0] norm_z;
        logic [TEX_W-1:0]         tex_u;
        logic [TEX_W-1:0]         tex_v;
        logic [INDEX_W-1:0]       idx_a;
        logic [INDEX_W-1:0]       idx_b;
    } item_t;

    // Rounds half away from zero after a right shift and limits the magnitude.
    function automatic logic [63:0] round_sat(input logic signed [63:0] p,
                                              input int unsigned sh,
                                              input logic [63:0] lim);
        logic        neg;
        logic [63:0] m;
        neg = p[63];
        m   = neg ? 64'(-p) : 64'(p);
        m   = (m + (64'd1 << (sh - 1))) >> sh;
        if (m > lim)
        begin
            m = lim;
        end
        return neg ? 64'(-m) : m;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/usm_stream_if.sv
`default_nettype none
// ============================================================================
// UV sphere mesh stream interfaces
// Request channel (grid items) and result channel (vertices and triangles).
// ============================================================================
interface usm_req_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [8:0] column;
    logic [8:0] row;

    modport source (output valid, operation, column, row, input ready);
    modport sink (input valid, operation, column, row, output ready);
endinterface

interface usm_res_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [16:0]        corner_first;
    logic [16:0]        corner_second;
    logic [16:0]        corner_third;
    logic               last;

    modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                    tex_u, tex_v, corner_first, corner_second, corner_third,
                    last, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  tex_u, tex_v, corner_first, corner_second, corner_third,
                  last, output ready);
endinterface
`default_nettype wire

FILE: rtl/usm_div.sv
`default_nettype none
// ============================================================================
// Pipelined rounding divider
// Computes (n * 2^(QW-1) + d/2) / d, one quotient bit per stage; stages past QW only hold it.
// ============================================================================
module usm_div
    import usm_pkg::*;
#(
    parameter int QW    = 17,
    parameter int STEPS = 17
)
(
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [COORD_W-1:0]   numer,
    input  wire logic [DIVISOR_W-1:0] divisor,
    output logic      [QW-1:0]        quot
);

    logic [DIVISOR_W-1:0] rem_reg [QW-1];
    logic [QW-1:0]        nq_reg  [STEPS];

    for (genvar i = 0; i < STEPS; i++)
    begin : g_stage
        logic [QW-1:0] q_src;

        if (i == 0)
        begin : g_first
            assign q_src = {numer[0], (QW-1)'(divisor >> 1)};
        end
        else
        begin : g_next
            assign q_src = nq_reg[i-1];
        end

        if (i < QW)
        begin : g_calc
            logic [DIVISOR_W-1:0] r_src;
            logic [DIVISOR_W:0]   r_sh;
            logic                 ge;
            if (i == 0)
            begin : g_r_first
                assign r_src = DIVISOR_W'(numer >> 1);
            end
            else
            begin : g_r_next
                assign r_src = rem_reg[i-1];
            end
            assign r_sh = {r_src, q_src[QW-1]};
            assign ge   = r_sh >= {1'b0, divisor};
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    nq_reg[i] <= {q_src[QW-2:0], ge};
                end
            end
            if (i < QW - 1)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[i] <= ge ? DIVISOR_W'(r_sh - {1'b0, divisor})
                                         : r_sh[DIVISOR_W-1:0];
                    end
                end
            end
        end
        else
        begin : g_hold
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    nq_reg[i] <= q_src;
                end
            end
        end
    end

    assign quot = nq_reg[STEPS-1];

endmodule
`default_nettype wire

FILE: rtl/usm_sine.sv
`default_nettype none
// ============================================================================
// Pipelined sine of a turn fraction
// Quadrant folding, then a Horner polynomial with one multiply per stage.
// ============================================================================
module usm_sine
    import usm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [ANGLE_W-1:0] angle,
    output logic signed [31:0]      sine
);

    localparam logic [30:0] HORNER [4] = '{K7, K5, K3, K1};

    logic [30:0]        x_reg   [1:6];
    logic               neg_reg [1:6];
    logic [30:0]        x2_reg  [2:5];
    logic [30:0]        t_reg   [3:6];
    logic signed [31:0] sine_reg;
    logic [30:0]        x_fold;
    logic [30:0]        s_raw;
    logic [30:0]        s_sat;

    function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
        logic [61:0] p;
        p = {31'b0, a} * {31'b0, b};
        return p[60:30];
    endfunction

    assign x_fold = angle[30] ? Q30_ONE - {1'b0, angle[29:0]} : {1'b0, angle[29:0]};
    assign s_raw  = mul_q30(x_reg[6], t_reg[6]);
    assign s_sat  = (s_raw > Q30_ONE) ? Q30_ONE : s_raw;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[1]   <= x_fold;
            neg_reg[1] <= angle[31];
            for (int i = 2; i <= 6; i++)
            begin
                x_reg[i]   <= x_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
            end
            x2_reg[2] <= mul_q30(x_reg[1], x_reg[1]);
            for (int i = 3; i <= 5; i++)
            begin
                x2_reg[i] <= x2_reg[i-1];
            end
            t_reg[3] <= HORNER[0] - mul_q30(x2_reg[2], K9);
            for (int i = 4; i <= 6; i++)
            begin
                t_reg[i] <= HORNER[i-3] - mul_q30(x2_reg[i-1], t_reg[i-1]);
            end
            sine_reg <= neg_reg[6] ? -$signed({1'b0, s_sat}) : $signed({1'b0, s_sat});
        end
    end

    assign sine = sine_reg;

endmodule
`default_nettype wire

FILE: rtl/usm_out.sv
`default_nettype none
// ============================================================================
// Result output stage
// Output register with a skid entry; a quad item leaves as two triangles.
// ============================================================================
module usm_out
    import usm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  pipe_valid,
    input  wire item_t pipe_item,
    output logic       pipe_ready,
    usm_res_if.source  result
);

    logic  out_valid_reg, out_valid_next;
    logic  phase_reg, phase_next;
    logic  skid_valid_reg, skid_valid_next;
    item_t out_item_reg, out_item_next;
    item_t skid_item_reg, skid_item_next;
    logic  xfer;
    logic  out_done;
    logic  out_free;
    logic  is_quad;

    assign is_quad    = out_item_reg.op == OP_QUAD;
    assign xfer       = out_valid_reg & result.ready;
    assign out_done   = xfer & (!is_quad | phase_reg);
    assign out_free   = !out_valid_reg | out_done;
    assign pipe_ready = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        phase_next      = phase_reg;
        skid_valid_next = skid_valid_reg;
        out_item_next   = out_item_reg;
        skid_item_next  = skid_item_reg;
        if (xfer && !out_done)
        begin
            phase_next = 1'b1;
        end
        if (out_done)
        begin
            out_valid_next = 1'b0;
            phase_next     = 1'b0;
        end
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                out_item_next   = skid_item_reg;
                phase_next      = 1'b0;
                skid_valid_next = 1'b0;
            end
        end
        else if (pipe_valid)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_item_next  = pipe_item;
                phase_next     = 1'b0;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_item_next  = pipe_item;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            phase_reg      <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            phase_reg      <= phase_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    always_comb
    begin
        result.valid         = out_valid_reg;
        result.pos_x         = '0;
        result.pos_y         = '0;
        result.pos_z         = '0;
        result.norm_x        = '0;
        result.norm_y        = '0;
        result.norm_z        = '0;
        result.tex_u         = '0;
        result.tex_v         = '0;
        result.corner_first  = '0;
        result.corner_second = '0;
        result.corner_third  = '0;
        result.last          = 1'b1;
        if (!is_quad)
        begin
            result.pos_x  = out_item_reg.pos_x;
            result.pos_y  = out_item_reg.pos_y;
            result.pos_z  = out_item_reg.pos_z;
            result.norm_x = out_item_reg.norm_x;
            result.norm_y = out_item_reg.norm_y;
            result.norm_z = out_item_reg.norm_z;
            result.tex_u  = out_item_reg.tex_u;
            result.tex_v  = out_item_reg.tex_v;
        end
        else if (!phase_reg)
        begin
            result.corner_first  = out_item_reg.idx_a;
            result.corner_second = out_item_reg.idx_b;
            result.corner_third  = out_item_reg.idx_a + INDEX_W'(1);
            result.last          = 1'b0;
        end
        else
        begin
            result.corner_first  = out_item_reg.idx_b;
            result.corner_second = out_item_reg.idx_b + INDEX_W'(1);
            result.corner_third  = out_item_reg.idx_a + INDEX_W'(1);
        end
    end

`ifndef SYNTH
    // The skid entry only fills while the output register is occupied.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds an item while the output register is empty");

    // The second triangle phase belongs to a quad item on show.
    a_phase_quad: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (out_valid_reg && is_quad))
        else $error("second triangle phase without a quad item");

    // After the first triangle's transfer, the second one follows from the same item.
    a_second_triangle: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && is_quad && !phase_reg) |=> (out_valid_reg && phase_reg && is_quad))
        else $error("second triangle of a quad was lost");
`endif

endmodule
`default_nettype wire

FILE: rtl/uv_sphere_mesh_generator_unit.sv
`default_nettype none
// Throughput: one vertex per cycle while the result port does not stall; a quad leaves as two
// triangles on the result port, and a full skid entry holds the whole pipeline.
// The pipeline runs through the input register, the 33-stage dividers, the 7-stage sine units,
// four product stages and the output register.
// Reset sets radius to 1.0, width segments to 32 and height segments to 16,
// and clears every valid bit; no clearing pass is needed.
// ============================================================================
// UV sphere mesh generator unit
// Grid items in, sphere vertices or quad triangles out, fully pipelined.
// ============================================================================
module uv_sphere_mesh_generator_unit
    import usm_pkg::*;
#(
    parameter int MAX_WIDTH_SEGMENTS  = 256,
    parameter int MAX_HEIGHT_SEGMENTS = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    usm_req_if.sink          request,
    usm_res_if.source        result
);

    localparam logic [12:0] MAX_WS = 13'(MAX_WIDTH_SEGMENTS);
    localparam logic [12:0] MAX_HS = 13'(MAX_HEIGHT_SEGMENTS);

    logic [RADIUS_W-1:0] radius_reg;
    logic [COORD_W-1:0]  wseg_reg;
    logic [COORD_W-1:0]  hseg_reg;
    logic [COORD_W-1:0]  ws;
    logic [COORD_W-1:0]  hs;
    logic                en;

    logic                v0_reg;
    op_t                 op0_reg;
    logic [COORD_W-1:0]  col0_reg;
    logic [COORD_W-1:0]  row0_reg;
    logic [COORD_W-1:0]  col_lim;
    logic [COORD_W-1:0]  row_lim;
    op_t                 req_op;

    logic [ANGLE_QW-1:0] q_phi;
    logic [ANGLE_QW-1:0] q_theta;
    logic [TEX_QW-1:0]   q_tu;
    logic [TEX_QW-1:0]   q_tv;

    logic signed [31:0]  sp, cp, st, ct;

    logic [9:0]          ws_p1;
    logic [18:0]         idx_a_full;
    logic [18:0]         idx_b_full;
    side_t               side_in;
    side_t               side_tex;
    side_t               side_reg [CHAIN_LEN];
    logic                vld_reg  [CHAIN_LEN];

    logic signed [63:0]  prod0_reg, prod2_reg;
    logic signed [31:0]  ct1_reg;
    logic signed [31:0]  dir_reg  [3];
    logic signed [63:0]  pprod_reg [3];
    logic signed [NORM_W-1:0] norm3_reg [3];
    logic signed [NORM_W-1:0] norm4_reg [3];
    logic signed [POS_W-1:0]  pos_reg  [3];
    logic signed [16:0]  rad_s;
    item_t               pipe_item;
    logic                pipe_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 16'd256;
            wseg_reg   <= 9'd32;
            hseg_reg   <= 9'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_RADIUS:          radius_reg <= cfg_data;
                CFG_WIDTH_SEGMENTS:  wseg_reg   <= cfg_data[COORD_W-1:0];
                CFG_HEIGHT_SEGMENTS: hseg_reg   <= cfg_data[COORD_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        if (wseg_reg < MIN_WIDTH_SEGMENTS)
        begin
            ws = MIN_WIDTH_SEGMENTS;
        end
        else if (13'(wseg_reg) > MAX_WS)
        begin
            ws = MAX_WS[COORD_W-1:0];
        end
        else
        begin
            ws = wseg_reg;
        end
        if (hseg_reg < MIN_HEIGHT_SEGMENTS)
        begin
            hs = MIN_HEIGHT_SEGMENTS;
        end
        else if (13'(hseg_reg) > MAX_HS)
        begin
            hs = MAX_HS[COORD_W-1:0];
        end
        else
        begin
            hs = hseg_reg;
        end
    end

    assign en            = pipe_ready;
    assign request.ready = en;

    assign req_op  = op_t'(request.operation);
    assign col_lim = (req_op == OP_QUAD) ? ws - COORD_W'(1) : ws;
    assign row_lim = (req_op == OP_QUAD) ? hs - COORD_W'(1) : hs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= request.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op0_reg  <= req_op;
            col0_reg <= (request.column > col_lim) ? col_lim : request.column;
            row0_reg <= (request.row > row_lim) ? row_lim : request.row;
        end
    end

    usm_div #(.QW(ANGLE_QW), .STEPS(DIV_STAGES)) u_div_phi (
        .clk(clk), .en(en), .numer(col0_reg), .divisor({1'b0, ws}), .quot(q_phi));
    usm_div #(.QW(ANGLE_QW), .STEPS(DIV_STAGES)) u_div_theta (
        .clk(clk), .en(en), .numer(row0_reg), .divisor({hs, 1'b0}), .quot(q_theta));
    usm_div #(.QW(TEX_QW), .STEPS(DIV_STAGES)) u_div_tex_u (
        .clk(clk), .en(en), .numer(col0_reg), .divisor({1'b0, ws}), .quot(q_tu));
    usm_div #(.QW(TEX_QW), .STEPS(DIV_STAGES)) u_div_tex_v (
        .clk(clk), .en(en), .numer(row0_reg), .divisor({1'b0, hs}), .quot(q_tv));

    usm_sine u_sin_phi (.clk(clk), .en(en), .angle(q_phi[ANGLE_W-1:0]), .sine(sp));
    usm_sine u_cos_phi (.clk(clk), .en(en),
                        .angle(q_phi[ANGLE_W-1:0] + QUARTER_TURN), .sine(cp));
    usm_sine u_sin_theta (.clk(clk), .en(en), .angle(q_theta[ANGLE_W-1:0]), .sine(st));
    usm_sine u_cos_theta (.clk(clk), .en(en),
                          .angle(q_theta[ANGLE_W-1:0] + QUARTER_TURN), .sine(ct));

    assign ws_p1      = {1'b0, ws} + 10'd1;
    assign idx_a_full = 19'(col0_reg) + 19'(ws_p1) * 19'(row0_reg);
    assign idx_b_full = idx_a_full + 19'(ws_p1);

    always_comb
    begin
        side_in.op    = op0_reg;
        side_in.idx_a = idx_a_full[INDEX_W-1:0];
        side_in.idx_b = idx_b_full[INDEX_W-1:0];
        side_in.tex_u = '0;
        side_in.tex_v = '0;
    end

    always_comb
    begin
        side_tex       = side_reg[DIV_STAGES-1];
        side_tex.tex_u = q_tu;
        side_tex.tex_v = TEX_ONE - q_tv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHAIN_LEN; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= v0_reg;
            for (int i = 1; i < CHAIN_LEN; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < CHAIN_LEN; i++)
            begin
                side_reg[i] <= (i == DIV_STAGES) ? side_tex : side_reg[i-1];
            end
        end
    end

    assign rad_s = $signed({1'b0, radius_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod0_reg  <= cp * st;
            prod2_reg  <= sp * st;
            ct1_reg    <= ct;
            dir_reg[0] <= 32'(round_sat(-prod0_reg, 30, DIR_LIMIT));
            dir_reg[1] <= ct1_reg;
            dir_reg[2] <= 32'(round_sat(prod2_reg, 30, DIR_LIMIT));
            for (int k = 0; k < 3; k++)
            begin
                pprod_reg[k] <= rad_s * dir_reg[k];
                norm3_reg[k] <= NORM_W'(round_sat(64'(dir_reg[k]), 15, NORM_LIMIT));
                pos_reg[k]   <= POS_W'(round_sat(pprod_reg[k], 30, POS_LIMIT));
                norm4_reg[k] <= norm3_reg[k];
            end
        end
    end

    always_comb
    begin
        pipe_item.op     = side_reg[CHAIN_LEN-1].op;
        pipe_item.pos_x  = pos_reg[0];
        pipe_item.pos_y  = pos_reg[1];
        pipe_item.pos_z  = pos_reg[2];
        pipe_item.norm_x = norm4_reg[0];
        pipe_item.norm_y = norm4_reg[1];
        pipe_item.norm_z = norm4_reg[2];
        pipe_item.tex_u  = side_reg[CHAIN_LEN-1].tex_u;
        pipe_item.tex_v  = side_reg[CHAIN_LEN-1].tex_v;
        pipe_item.idx_a  = side_reg[CHAIN_LEN-1].idx_a;
        pipe_item.idx_b  = side_reg[CHAIN_LEN-1].idx_b;
    end

    usm_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .pipe_valid (vld_reg[CHAIN_LEN-1]),
        .pipe_item  (pipe_item),
        .pipe_ready (pipe_ready),
        .result     (result)
    );

endmodule
`default_nettype wire

FILE: verif/uv_sphere_mesh_generator_unit_tb.sv
// ============================================================================
// UV sphere mesh generator unit testbench
// Drives grid items with random idling on both channels, predicts each vertex
// and triangle in fixed point, and checks every result transfer in order.
// The run passes through several radius and segment settings.
// ============================================================================
module uv_sphere_mesh_generator_unit_tb;
    import usm_pkg::*;

    typedef struct {
        logic signed [16:0] pos_x;
        logic signed [16:0] pos_y;
        logic signed [16:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic [16:0]        corner_first;
        logic [16:0]        corner_second;
        logic [16:0]        corner_third;
        logic               last;
    } mesh_out_t;

    class mesh_scoreboard;
        logic [15:0] radius_q;
        logic [8:0]  width_q;
        logic [8:0]  height_q;
        mesh_out_t   pending[$];
        int          failures;

        function new();
            radius_q = 16'd256;
            width_q  = 9'd32;
            height_q = 9'd16;
            failures = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [15:0] value);
            case (idx)
                CFG_RADIUS:          radius_q = value;
                CFG_WIDTH_SEGMENTS:  width_q = value[8:0];
                CFG_HEIGHT_SEGMENTS: height_q = value[8:0];
                default:             ;
            endcase
        endfunction

        function longint unsigned turn_of(longint unsigned n, longint unsigned d);
            return (((n << 32) + (d >> 1)) / d) & 64'hFFFF_FFFF;
        endfunction

        function longint quarter_sin(longint unsigned x);
            longint unsigned x2;
            longint unsigned t;
            longint unsigned s;
            x2 = (x * x) >> 30;
            t = 64'd5026995 - ((x2 * 64'd172272) >> 30);
            t = 64'd85569306 - ((x2 * t) >> 30);
            t = 64'd693598668 - ((x2 * t) >> 30);
            t = 64'd1686629713 - ((x2 * t) >> 30);
            s = (x * t) >> 30;
            if (s > 64'h4000_0000)
            begin
                s = 64'h4000_0000;
            end
            return longint'(s);
        endfunction

        function longint sin_of(longint unsigned a);
            longint unsigned q;
            longint unsigned f;
            longint m;
            q = (a >> 30) & 3;
            f = a & 64'h3FFF_FFFF;
            m = q[0] ? quarter_sin(64'h4000_0000 - f) : quarter_sin(f);
            return q[1] ? -m : m;
        endfunction

        function longint cos_of(longint unsigned a);
            return sin_of((a + 64'h4000_0000) & 64'hFFFF_FFFF);
        endfunction

        function longint rnd_sat(longint p, int sh, longint unsigned lim);
            longint unsigned m;
            m = (p < 0) ? longint'(-p) : p;
            m = (m + (64'd1 << (sh - 1))) >> sh;
            if (m > lim)
            begin
                m = lim;
            end
            return (p < 0) ? -longint'(m) : longint'(m);
        endfunction

        function void note_item(op_t op, logic [8:0] col_in, logic [8:0] row_in);
            longint unsigned ws;
            longint unsigned hs;
            longint unsigned col;
            longint unsigned row;
            longint unsigned ap;
            longint unsigned at;
            longint unsigned a;
            longint unsigned b;
            longint sp;
            longint cp;
            longint st;
            longint ct;
            longint dir[3];
            longint pos[3];
            longint nrm[3];
            mesh_out_t r;
            ws = width_q;
            hs = height_q;
            if (ws < 3) ws = 3;
            if (ws > 256) ws = 256;
            if (hs < 2) hs = 2;
            if (hs > 256) hs = 256;
            col = col_in;
            row = row_in;
            r = '{default: '0};
            if (op == OP_VERTEX)
            begin
                if (col > ws) col = ws;
                if (row > hs) row = hs;
                ap = turn_of(col, ws);
                at = turn_of(row, 2 * hs);
                sp = sin_of(ap);
                cp = cos_of(ap);
                st = sin_of(at);
                ct = cos_of(at);
                dir[0] = rnd_sat(-(cp * st), 30, 64'h4000_0000);
                dir[1] = ct;
                dir[2] = rnd_sat(sp * st, 30, 64'h4000_0000);
                for (int k = 0; k < 3; k++)
                begin
                    pos[k] = rnd_sat(longint'(radius_q) * dir[k], 30, 65535);
                    nrm[k] = rnd_sat(dir[k], 15, 32767);
                end
                r.pos_x = pos[0][16:0];
                r.pos_y = pos[1][16:0];
                r.pos_z = pos[2][16:0];
                r.norm_x = nrm[0][15:0];
                r.norm_y = nrm[1][15:0];
                r.norm_z = nrm[2][15:0];
                r.tex_u = 17'(((col << 16) + (ws >> 1)) / ws);
                r.tex_v = 17'(65536 - (((row << 16) + (hs >> 1)) / hs));
                r.last = 1'b1;
                pending.push_back(r);
            end
            else
            begin
                if (col > ws - 1) col = ws - 1;
                if (row > hs - 1) row = hs - 1;
                a = col + (ws + 1) * row;
                b = col + (ws + 1) * (row + 1);
                r.corner_first = a[16:0];
                r.corner_second = b[16:0];
                r.corner_third = 17'(a + 1);
                pending.push_back(r);
                r.corner_first = b[16:0];
                r.corner_second = 17'(b + 1);
                r.last = 1'b1;
                pending.push_back(r);
            end
        endfunction

        function void cmp(string name, longint e, longint a);
            if (e != a)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, e, a);
                failures++;
            end
        endfunction

        function void check_result(mesh_out_t got);
            mesh_out_t e;
            if (pending.size() == 0)
            begin
                $error("Result transfer with no expected result waiting");
                failures++;
                return;
            end
            e = pending.pop_front();
            cmp("pos_x", e.pos_x, got.pos_x);
            cmp("pos_y", e.pos_y, got.pos_y);
            cmp("pos_z", e.pos_z, got.pos_z);
            cmp("norm_x", e.norm_x, got.norm_x);
            cmp("norm_y", e.norm_y, got.norm_y);
            cmp("norm_z", e.norm_z, got.norm_z);
            cmp("tex_u", e.tex_u, got.tex_u);
            cmp("tex_v", e.tex_v, got.tex_v);
            cmp("corner_first", e.corner_first, got.corner_first);
            cmp("corner_second", e.corner_second, got.corner_second);
            cmp("corner_third", e.corner_third, got.corner_third);
            cmp("last", e.last, got.last);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    bit          calm;
    int          cycle_count;
    mesh_scoreboard board;

    usm_req_if request ();
    usm_res_if result ();

    uv_sphere_mesh_generator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (request.sink),
        .result    (result.source)
    );

    always
    begin
        #5;
        clk = 1'b1;
        #5;
        clk = 1'b0;
    end

    always @(posedge clk)
    begin
        mesh_out_t got;
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("Test completed with failures");
            $finish;
        end
        if (rst_n && request.valid && request.ready)
        begin
            board.note_item(op_t'(request.operation), request.column, request.row);
        end
        if (rst_n && result.valid && result.ready)
        begin
            got.pos_x = result.pos_x;
            got.pos_y = result.pos_y;
            got.pos_z = result.pos_z;
            got.norm_x = result.norm_x;
            got.norm_y = result.norm_y;
            got.norm_z = result.norm_z;
            got.tex_u = result.tex_u;
            got.tex_v = result.tex_v;
            got.corner_first = result.corner_first;
            got.corner_second = result.corner_second;
            got.corner_third = result.corner_third;
            got.last = result.last;
            board.check_result(got);
        end
    end

    // The receiver stalls in bursts until the calm part of the run.
    initial
    begin
        int stall;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                result.ready <= 1'b0;
                stall = $urandom_range(1, 16);
                repeat (stall) @(negedge clk);
            end
            result.ready <= 1'b1;
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [15:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.set_reg(idx, value);
    endtask

    task automatic send_item(op_t op, logic [8:0] col, logic [8:0] row);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            request.valid <= 1'b0;
            gap = $urandom_range(1, 16);
            repeat (gap) @(negedge clk);
        end
        request.valid <= 1'b1;
        request.operation <= op;
        request.column <= col;
        request.row <= row;
        do
            @(posedge clk);
        while (!request.ready);
        @(negedge clk);
    endtask

    task automatic drain();
        int guard;
        request.valid <= 1'b0;
        guard = 0;
        while (board.pending.size() != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (60) @(negedge clk);
    endtask

    task automatic set_shape(logic [15:0] rad, logic [15:0] ws, logic [15:0] hs);
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_WIDTH_SEGMENTS, ws);
        write_reg(CFG_HEIGHT_SEGMENTS, hs);
    endtask

    task automatic random_phase(int count);
        int ws;
        int hs;
        op_t op;
        logic [8:0] col;
        logic [8:0] row;
        ws = (board.width_q < 3) ? 3 : int'(board.width_q);
        hs = (board.height_q < 2) ? 2 : int'(board.height_q);
        for (int i = 0; i < count; i++)
        begin
            op = op_t'($urandom_range(0, 1));
            if ($urandom_range(0, 7) == 0)
            begin
                col = 9'($urandom);
                row = 9'($urandom);
            end
            else
            begin
                col = 9'($urandom_range(0, ws));
                row = 9'($urandom_range(0, hs));
            end
            send_item(op, col, row);
        end
    endtask

    initial
    begin
        board = new();
        cycle_count = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_RADIUS;
        cfg_data = '0;
        request.valid = 1'b0;
        request.operation = OP_VERTEX;
        request.column = '0;
        request.row = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        send_item(OP_VERTEX, 9'd0, 9'd0);
        send_item(OP_VERTEX, 9'd32, 9'd16);
        send_item(OP_VERTEX, 9'd8, 9'd8);
        send_item(OP_VERTEX, 9'd511, 9'd511);
        send_item(OP_VERTEX, 9'd16, 9'd4);
        send_item(OP_QUAD, 9'd0, 9'd0);
        send_item(OP_QUAD, 9'd511, 9'd511);
        send_item(OP_QUAD, 9'd31, 9'd15);
        drain();
        set_shape(16'hFFFF, 16'd256, 16'd256);
        send_item(OP_VERTEX, 9'd256, 9'd256);
        send_item(OP_VERTEX, 9'd85, 9'd170);
        send_item(OP_VERTEX, 9'd511, 9'd1);
        send_item(OP_QUAD, 9'd255, 9'd255);
        send_item(OP_QUAD, 9'd300, 9'd300);
        drain();
        set_shape(16'd0, 16'd0, 16'd0);
        send_item(OP_VERTEX, 9'd1, 9'd1);
        send_item(OP_VERTEX, 9'd3, 9'd2);
        send_item(OP_QUAD, 9'd5, 9'd5);
        drain();
        set_shape(16'd1, 16'd511, 16'd511);
        send_item(OP_VERTEX, 9'd100, 9'd100);
        send_item(OP_QUAD, 9'd100, 9'd100);
        drain();

        set_shape(16'd256, 16'd32, 16'd16);
        random_phase(300);
        drain();
        set_shape(16'($urandom), 16'($urandom_range(3, 256)), 16'($urandom_range(2, 256)));
        random_phase(300);
        drain();
        set_shape(16'hFFFF, 16'd3, 16'd2);
        random_phase(250);
        drain();
        set_shape(16'($urandom), 16'($urandom), 16'($urandom));
        random_phase(300);
        drain();
        set_shape(16'($urandom_range(1, 1024)), 16'd256, 16'd256);
        random_phase(250);
        drain();
        calm = 1'b1;
        set_shape(16'($urandom), 16'($urandom_range(3, 64)), 16'($urandom_range(2, 64)));
        random_phase(200);
        drain();

        if (board.failures == 0 && board.pending.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            if (board.pending.size() != 0)
            begin
                $error("%0d expected results never arrived", board.pending.size());
            end
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

FILE: sim.f
rtl/usm_pkg.sv
rtl/usm_stream_if.sv
rtl/usm_div.sv
rtl/usm_sine.sv
rtl/usm_out.sv
rtl/uv_sphere_mesh_generator_unit.sv
verif/uv_sphere_mesh_generator_unit_tb.sv
